// ===== rtl/core/ssd_pkg.sv =====
package ssd_pkg;

  // Sizes of the frame store, the scan rotation and the time stamps.
  localparam int FRAME_DEPTH = 16;
  localparam int MAX_DIGITS  = 8;
  localparam int TIME_WIDTH  = 32;

  // Derived widths: store address, cursor (holds FRAME_DEPTH itself), scan index.
  localparam int FRAME_AW = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
  localparam int CUR_W    = $clog2(FRAME_DEPTH + 1);
  localparam int SCAN_W   = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  // Field widths of the channels and the configuration port.
  localparam int CHAR_W    = 8;
  localparam int SEG_W     = 8;
  localparam int SEL_W     = 8;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int DCOUNT_W  = 4;
  localparam int FSIZE_W   = 5;

  // Item kinds.
  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_SCAN = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_POWER_ON     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_ENABLE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_PERIOD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIGIT_COUNT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_SIZE   = 3'd4;

  // Configuration reset values.
  localparam logic [CFG_W-1:0]    BLINK_PERIOD_RST = 32'd500000;
  localparam logic [DCOUNT_W-1:0] DIGIT_COUNT_RST  = 4'd4;
  localparam logic [FSIZE_W-1:0]  FRAME_SIZE_RST   = 5'd8;

  // Control characters.
  localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;
  localparam logic [CHAR_W-1:0] CH_BS  = 8'h08;
  localparam logic [CHAR_W-1:0] CH_LF  = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_VT  = 8'h0B;
  localparam logic [CHAR_W-1:0] CH_FF  = 8'h0C;
  localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_DOT = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_0   = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9   = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UA  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UZ  = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LA  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LZ  = 8'h7A;
  localparam logic [CHAR_W-1:0] CH_USC = 8'h5F;
  localparam logic [CHAR_W-1:0] CH_MIN = 8'h2D;

  // Segment patterns.
  localparam logic [SEG_W-1:0] DOT_MASK  = 8'h80;
  localparam logic [SEG_W-1:0] GLYPH_USC = 8'h08;
  localparam logic [SEG_W-1:0] GLYPH_MIN = 8'h40;

  localparam logic [SEG_W-1:0] GLYPH_DIGIT [10] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h67};
  localparam logic [SEG_W-1:0] GLYPH_UPPER [26] = '{
    8'h77, 8'h00, 8'h39, 8'h00, 8'h79, 8'h71, 8'h7D,
    8'h76, 8'h30, 8'h0E, 8'h00, 8'h38, 8'h00, 8'h00,
    8'h3F, 8'h73, 8'h00, 8'h00, 8'h6D, 8'h00, 8'h3E,
    8'h00, 8'h00, 8'h00, 8'h6E, 8'h00};
  localparam logic [SEG_W-1:0] GLYPH_LOWER [26] = '{
    8'h00, 8'h7C, 8'h58, 8'h5E, 8'h7B, 8'h00, 8'h00,
    8'h74, 8'h10, 8'h00, 8'h00, 8'h30, 8'h00, 8'h54,
    8'h5C, 8'h00, 8'h00, 8'h50, 8'h00, 8'h78, 8'h1C,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00};

  // Font lookup; codes without a glyph give a blank pattern.
  function automatic logic [SEG_W-1:0] glyph_of(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] off;
    logic [SEG_W-1:0]  g;
    off = '0;
    g   = '0;
    if (c >= CH_0 && c <= CH_9) begin
      off = c - CH_0;
      g   = GLYPH_DIGIT[off[3:0]];
    end else if (c >= CH_UA && c <= CH_UZ) begin
      off = c - CH_UA;
      g   = GLYPH_UPPER[off[4:0]];
    end else if (c >= CH_LA && c <= CH_LZ) begin
      off = c - CH_LA;
      g   = GLYPH_LOWER[off[4:0]];
    end else if (c == CH_USC) begin
      g = GLYPH_USC;
    end else if (c == CH_MIN) begin
      g = GLYPH_MIN;
    end
    return g;
  endfunction

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic exec;
  } ssd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_scan;
    logic out_blocked;
  } ssd_stat_t;

endpackage

// ===== rtl/core/ssd_in_if.sv =====
interface ssd_in_if;
  logic                           valid;
  logic                           ready;
  logic                           kind;
  logic [ssd_pkg::CHAR_W-1:0]     char_code;
  logic [31:0]                    now_time;

  modport source (output valid, output kind, output char_code, output now_time,
                  input ready);
  modport sink (input valid, input kind, input char_code, input now_time,
                output ready);
endinterface

// ===== rtl/core/ssd_out_if.sv =====
interface ssd_out_if;
  logic                        valid;
  logic                        ready;
  logic [ssd_pkg::SEG_W-1:0]   segment_bits;
  logic [ssd_pkg::SEL_W-1:0]   digit_select;

  modport source (output valid, output segment_bits, output digit_select,
                  input ready);
  modport sink (input valid, input segment_bits, input digit_select,
                output ready);
endinterface

// ===== rtl/core/ssd_ctrl.sv =====
module ssd_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ssd_pkg::ssd_stat_t stat,
  output ssd_pkg::ssd_cmd_t  cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_r;
  logic state_nxt;

  // One item at a time: take it in idle, carry it out in the next state.
  always_comb begin
    in_ready   = (state_r == ST_IDLE);
    cmd.accept = in_ready && in_valid;
    cmd.exec   = (state_r == ST_EXEC) && !(stat.is_scan && stat.out_blocked);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.accept) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (cmd.exec) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // An accepted item is always followed by an execution cycle.
  a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> !in_ready)
    else $error("controller took an item without moving to execution");

endmodule

// ===== rtl/core/ssd_dpath.sv =====
module ssd_dpath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ssd_pkg::ssd_cmd_t                   cmd,
  output ssd_pkg::ssd_stat_t                  stat,
  // Item payload.
  input  logic                                in_kind,
  input  logic [ssd_pkg::CHAR_W-1:0]          in_char_code,
  input  logic [31:0]                         in_now_time,
  // Configuration writes.
  input  logic                                cfg_we,
  input  logic [ssd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ssd_pkg::CFG_W-1:0]           cfg_data,
  // Result register.
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [ssd_pkg::SEG_W-1:0]           out_segment_bits,
  output logic [ssd_pkg::SEL_W-1:0]           out_digit_select
);

  localparam int AW  = ssd_pkg::FRAME_AW;
  localparam int CW  = ssd_pkg::CUR_W;
  localparam int SW  = ssd_pkg::SCAN_W;
  localparam int TW  = ssd_pkg::TIME_WIDTH;

  // Configuration registers.
  logic                          power_on_r;
  logic                          blink_en_r;
  logic [ssd_pkg::CFG_W-1:0]     blink_period_r;
  logic [ssd_pkg::DCOUNT_W-1:0]  digit_count_r;
  logic [ssd_pkg::FSIZE_W-1:0]   frame_size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      power_on_r     <= 1'b0;
      blink_en_r     <= 1'b0;
      blink_period_r <= ssd_pkg::BLINK_PERIOD_RST;
      digit_count_r  <= ssd_pkg::DIGIT_COUNT_RST;
      frame_size_r   <= ssd_pkg::FRAME_SIZE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ssd_pkg::CFG_POWER_ON:     power_on_r     <= cfg_data[0];
        ssd_pkg::CFG_BLINK_ENABLE: blink_en_r     <= cfg_data[0];
        ssd_pkg::CFG_BLINK_PERIOD: blink_period_r <= cfg_data;
        ssd_pkg::CFG_DIGIT_COUNT:  digit_count_r  <= cfg_data[ssd_pkg::DCOUNT_W-1:0];
        ssd_pkg::CFG_FRAME_SIZE:   frame_size_r   <= cfg_data[ssd_pkg::FSIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Control state.
  logic [CW-1:0]           cursor_r, cursor_nxt;
  logic [SW-1:0]           scan_idx_r, scan_idx_nxt;
  logic                    visible_r, visible_nxt;
  logic [TW-1:0]           mark_r, mark_nxt;
  logic [ssd_pkg::FRAME_DEPTH-1:0] fvalid_r, fvalid_nxt;
  logic                    out_valid_r, out_valid_nxt;

  // Item and read data held from the accept edge.
  logic                          kind_r;
  logic [ssd_pkg::CHAR_W-1:0]    char_r;
  logic [TW-1:0]                 now_r;
  logic [ssd_pkg::SEG_W-1:0]     rd_data_r;
  logic                          rd_hit_r;
  logic [ssd_pkg::SEG_W-1:0]     seg_r, seg_nxt;
  logic [ssd_pkg::SEL_W-1:0]     sel_r, sel_nxt;

  // Frame store memory.
  logic [ssd_pkg::SEG_W-1:0]     mem_r [ssd_pkg::FRAME_DEPTH];
  logic                          wr_en;
  logic [AW-1:0]                 wr_addr;
  logic [ssd_pkg::SEG_W-1:0]     wr_data;

  // Effective sizes.
  logic [CW-1:0]                 size_eff;
  logic [ssd_pkg::DCOUNT_W-1:0]  digits_eff;

  always_comb begin
    size_eff = (32'(frame_size_r) > 32'(ssd_pkg::FRAME_DEPTH)) ?
               CW'(ssd_pkg::FRAME_DEPTH) : CW'(frame_size_r);
    digits_eff = (32'(digit_count_r) > 32'(ssd_pkg::MAX_DIGITS)) ?
                 ssd_pkg::DCOUNT_W'(ssd_pkg::MAX_DIGITS) : digit_count_r;
  end

  // Read address at accept: scan digit or the entry before the cursor.
  logic [CW-1:0] rd_full;
  logic          rd_in_range;

  always_comb begin
    rd_full     = (in_kind == ssd_pkg::KIND_SCAN) ? CW'(scan_idx_r) : cursor_r - CW'(1);
    rd_in_range = (32'(rd_full) < 32'(ssd_pkg::FRAME_DEPTH));
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_r    <= in_kind;
      char_r    <= in_char_code;
      now_r     <= in_now_time[TW-1:0];
      rd_data_r <= mem_r[rd_full[AW-1:0]];
      rd_hit_r  <= rd_in_range && fvalid_r[rd_full[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_addr] <= wr_data;
  end

  // Entry value as read; a never-written or cleared entry reads zero.
  logic [ssd_pkg::SEG_W-1:0] rd_val;
  logic [TW-1:0]             elapsed;
  logic                      vis_now;
  logic [SW:0]               scan_inc;

  assign rd_val = rd_hit_r ? rd_data_r : '0;

  // Address of the entry before a nonzero cursor.
  function automatic logic [AW-1:0] rd_full_exec(input logic [CW-1:0] cur);
    logic [CW-1:0] prev;
    prev = cur - CW'(1);
    return prev[AW-1:0];
  endfunction

  // Execution of the held item.
  always_comb begin
    cursor_nxt    = cursor_r;
    scan_idx_nxt  = scan_idx_r;
    visible_nxt   = visible_r;
    mark_nxt      = mark_r;
    fvalid_nxt    = fvalid_r;
    seg_nxt       = seg_r;
    sel_nxt       = sel_r;
    wr_en         = 1'b0;
    wr_addr       = cursor_r[AW-1:0];
    wr_data       = '0;
    elapsed       = now_r - mark_r;
    vis_now       = visible_r;
    scan_inc      = {1'b0, scan_idx_r} + (SW+1)'(1);
    out_valid_nxt = (out_valid_r && out_ready) ? 1'b0 : out_valid_r;

    if (cmd.exec && kind_r == ssd_pkg::KIND_SCAN) begin
      out_valid_nxt = 1'b1;
      seg_nxt       = '0;
      sel_nxt       = '0;
      if (!power_on_r) begin
        scan_idx_nxt = SW'(1);
      end else begin
        // Blink phase tracking from the item time stamp.
        if (!blink_en_r) begin
          vis_now  = 1'b1;
          mark_nxt = now_r;
        end else if (32'(elapsed) > blink_period_r) begin
          vis_now  = !visible_r;
          mark_nxt = now_r;
        end
        visible_nxt = vis_now;
        if (vis_now) begin
          seg_nxt = rd_val;
          sel_nxt = ssd_pkg::SEL_W'(1) << scan_idx_r;
        end
        // Scan rotation wraps at the effective digit count.
        if (32'(scan_inc) >= 32'(digits_eff)) scan_idx_nxt = '0;
        else                                  scan_idx_nxt = scan_inc[SW-1:0];
      end
    end else if (cmd.exec) begin
      case (char_r)
        ssd_pkg::CH_NUL: ;
        ssd_pkg::CH_CR: cursor_nxt = '0;
        ssd_pkg::CH_LF, ssd_pkg::CH_VT, ssd_pkg::CH_FF: begin
          for (int i = 0; i < ssd_pkg::FRAME_DEPTH; i++) begin
            if (32'(i) < 32'(size_eff)) fvalid_nxt[i] = 1'b0;
          end
          cursor_nxt = '0;
        end
        ssd_pkg::CH_BS: begin
          if (cursor_r != '0) cursor_nxt = cursor_r - CW'(1);
          if (32'(cursor_nxt) < 32'(ssd_pkg::FRAME_DEPTH)) begin
            fvalid_nxt[cursor_nxt[AW-1:0]] = 1'b0;
          end
        end
        default: begin
          if (cursor_r < size_eff) begin
            wr_en = 1'b1;
            if (char_r == ssd_pkg::CH_DOT) begin
              if (cursor_r == '0) begin
                wr_addr = '0;
                wr_data = ssd_pkg::DOT_MASK;
              end else begin
                wr_addr = rd_full_exec(cursor_r);
                wr_data = rd_val | ssd_pkg::DOT_MASK;
              end
            end else begin
              wr_addr    = cursor_r[AW-1:0];
              wr_data    = ssd_pkg::glyph_of(char_r);
              cursor_nxt = cursor_r + CW'(1);
            end
            fvalid_nxt[wr_addr] = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r    <= '0;
      scan_idx_r  <= '0;
      visible_r   <= 1'b1;
      mark_r      <= '0;
      fvalid_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cursor_r    <= cursor_nxt;
      scan_idx_r  <= scan_idx_nxt;
      visible_r   <= visible_nxt;
      mark_r      <= mark_nxt;
      fvalid_r    <= fvalid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    seg_r <= seg_nxt;
    sel_r <= sel_nxt;
  end

  // Status and result outputs.
  always_comb begin
    stat.is_scan     = (kind_r == ssd_pkg::KIND_SCAN);
    stat.out_blocked = out_valid_r && !out_ready;
    out_valid        = out_valid_r;
    out_segment_bits = seg_r;
    out_digit_select = sel_r;
  end

  // A scan never overwrites a result that has not been transferred.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.exec && stat.is_scan && out_valid_r && !out_ready))
    else $error("scan result overwrote a pending transfer");

  // A scan while powered off parks the rotation at digit one.
  a_power_off_index: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && stat.is_scan && !power_on_r) |=> (scan_idx_r == SW'(1)))
    else $error("power-off scan did not set the scan index to one");

  // The cursor never passes the end of the frame store.
  a_cursor_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cursor_r) <= 32'(ssd_pkg::FRAME_DEPTH))
    else $error("write cursor beyond the frame store");

  // At most one digit is enabled in any result.
  a_select_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot0(sel_r))
    else $error("digit select is not one-hot");

endmodule

// ===== rtl/core/seven_segment_text_scan_controller_unit.sv =====
// Each item is registered at its transfer in and carried out in the execution state
// that follows; a scan item's result is registered at the end of its execution.
// Items are taken one at a time: a new item is not accepted until the last one has
// executed, and a scan waits in execution while the previous result is not yet taken.
// Reset (synchronous, rst_n low) clears the frame store valid bits at once,
// homes cursor and scan index, shows the display, and loads config defaults.
module seven_segment_text_scan_controller_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  ssd_in_if.sink                          in_chan,
  ssd_out_if.source                       out_chan,
  input  logic                            cfg_we,
  input  logic [ssd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ssd_pkg::CFG_W-1:0]       cfg_data
);

  ssd_pkg::ssd_cmd_t  cmd;
  ssd_pkg::ssd_stat_t stat;
  logic               in_ready;

  assign in_chan.ready = in_ready;

  ssd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ssd_dpath u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_kind          (in_chan.kind),
    .in_char_code     (in_chan.char_code),
    .in_now_time      (in_chan.now_time),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_valid        (out_chan.valid),
    .out_ready        (out_chan.ready),
    .out_segment_bits (out_chan.segment_bits),
    .out_digit_select (out_chan.digit_select)
  );

endmodule
